/* hw/rtl/wheel_speed_pid_controller_top_defines.svh */
// ----------------------------------------------------------------------------
// wheel speed pid controller assertion macros
// shared helpers for the concurrent checks bound to the top level
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_PID_CONTROLLER_TOP_DEFINES_SVH
`define WHEEL_SPEED_PID_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WSPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wspid check failed");

// next-cycle implication, disabled while in reset
`define WSPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wspid check failed");

`endif

/* hw/rtl/wspid_pkg.sv */
// ----------------------------------------------------------------------------
// wspid_pkg
// types, constants, microcode table and helpers of the wheel speed pid block
// ----------------------------------------------------------------------------
package wspid_pkg;

    localparam int WSPID_COUNTER_BITS = 16;

    localparam logic [31:0] LIN_K = 32'd876602825;
    localparam logic [31:0] ANG_K = 32'd5763332;

    localparam logic [15:0] KP_RST  = 16'd1280;
    localparam logic [15:0] KI_RST  = 16'd77;
    localparam logic [15:0] KD_RST  = 16'd0;
    localparam logic [31:0] THR_RST = 32'd19661;
    localparam logic [7:0]  LIM_RST = 8'd80;
    localparam logic [31:0] C2R_RST = 32'd4588636;
    localparam logic [31:0] M2R_RST = 32'd21043622;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C2R = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_M2R = 3'd6;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] ST_RPS_MUL = 4'd0;
    localparam logic [PC_W-1:0] ST_SP_MUL  = 4'd1;
    localparam logic [PC_W-1:0] ST_LIN_MUL = 4'd2;
    localparam logic [PC_W-1:0] ST_ANG_MUL = 4'd3;
    localparam logic [PC_W-1:0] ST_KP_MUL  = 4'd4;
    localparam logic [PC_W-1:0] ST_KI_MUL  = 4'd5;
    localparam logic [PC_W-1:0] ST_KD_MUL  = 4'd6;
    localparam logic [PC_W-1:0] ST_KD_ADD  = 4'd7;
    localparam logic [PC_W-1:0] ST_FINISH  = 4'd8;

    typedef enum logic [2:0] {
        A_COUNT, A_MAG, A_RPS, A_STORE, A_ERR, A_INTEG, A_DERR
    } t_asel;

    typedef enum logic [2:0] {
        B_C2R, B_M2R, B_LIN, B_ANG, B_KP, B_KI, B_KD
    } t_bsel;

    typedef enum logic [2:0] {
        DST_NONE, DST_RPS, DST_SP, DST_LIN, DST_ANG
    } t_dst;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD
    } t_acc;

    typedef enum logic {
        JMP_NEVER, JMP_KD_ZERO
    } t_jmp;

    typedef struct packed {
        t_asel           a_sel;
        t_bsel           b_sel;
        t_dst            dst;
        logic            err_ld;
        logic            integ_ld;
        t_acc            acc_op;
        logic            fin;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uop;

    typedef struct packed {
        logic active;
        logic adv;
        t_uop uop;
    } t_ctrl;

    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        u.a_sel    = A_COUNT;
        u.b_sel    = B_C2R;
        u.dst      = DST_NONE;
        u.err_ld   = 1'b0;
        u.integ_ld = 1'b0;
        u.acc_op   = ACC_NONE;
        u.fin      = 1'b0;
        u.jmp      = JMP_NEVER;
        u.target   = ST_RPS_MUL;
        case (pc)
            ST_RPS_MUL: begin
                u.a_sel = A_COUNT;
                u.b_sel = B_C2R;
            end
            ST_SP_MUL: begin
                u.dst   = DST_RPS;
                u.a_sel = A_MAG;
                u.b_sel = B_M2R;
            end
            ST_LIN_MUL: begin
                u.dst   = DST_SP;
                u.a_sel = A_RPS;
                u.b_sel = B_LIN;
            end
            ST_ANG_MUL: begin
                u.dst    = DST_LIN;
                u.err_ld = 1'b1;
                u.a_sel  = A_STORE;
                u.b_sel  = B_ANG;
            end
            ST_KP_MUL: begin
                u.dst      = DST_ANG;
                u.integ_ld = 1'b1;
                u.a_sel    = A_ERR;
                u.b_sel    = B_KP;
            end
            ST_KI_MUL: begin
                u.acc_op = ACC_LOAD;
                u.a_sel  = A_INTEG;
                u.b_sel  = B_KI;
            end
            ST_KD_MUL: begin
                u.acc_op = ACC_ADD;
                u.a_sel  = A_DERR;
                u.b_sel  = B_KD;
                u.jmp    = JMP_KD_ZERO;
                u.target = ST_FINISH;
            end
            ST_KD_ADD: begin
                u.acc_op = ACC_ADD;
            end
            ST_FINISH: begin
                u.fin = 1'b1;
            end
            default: begin
                u.fin = 1'b1;
            end
        endcase
        return u;
    endfunction

    // q32.32 product to q16.16, round half up, cap at 2^31 - 1
    function automatic logic [30:0] wspid_scale(input logic [63:0] p);
        logic [48:0] r;
        r = {1'b0, p[63:16]} + {48'd0, p[15]};
        if (r > 49'h7FFF_FFFF) begin
            return 31'h7FFF_FFFF;
        end else begin
            return r[30:0];
        end
    endfunction

endpackage

/* hw/rtl/wspid_if.sv */
// ----------------------------------------------------------------------------
// wspid channel interfaces
// valid/ready channels for the input word and the result word
// ----------------------------------------------------------------------------
interface wspid_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        encoder_count;
    logic               counting_down;
    logic signed [15:0] wheel_setpoint;
    logic signed [15:0] partner_setpoint;

    modport source (
        output valid, encoder_count, counting_down, wheel_setpoint, partner_setpoint,
        input  ready
    );
    modport sink (
        input  valid, encoder_count, counting_down, wheel_setpoint, partner_setpoint,
        output ready
    );
endinterface

interface wspid_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pwm_duty;
    logic [1:0]  motor_dir;
    logic [30:0] wheel_rps;
    logic [30:0] linear_speed;
    logic [30:0] turn_angle;
    logic        turning;

    modport source (
        output valid, pwm_duty, motor_dir, wheel_rps, linear_speed, turn_angle, turning,
        input  ready
    );
    modport sink (
        input  valid, pwm_duty, motor_dir, wheel_rps, linear_speed, turn_angle, turning,
        output ready
    );
endinterface

/* hw/rtl/wheel_speed_pid_controller_top.sv */
// ----------------------------------------------------------------------------
// wheel_speed_pid_controller_top
// encoder speed measurement, pid with integral separation, pwm accumulator
//
// channel  dir  handshake          word
// i_in     in   valid / ready      count, down flag, wheel and partner setpoint
// o_out    out  valid / ready      pwm duty, direction, speeds, turn angle
// i_cfg    in   write enable only  register index and 32-bit data
//
// one word per pass of the nine-step microcode program, the kd add step
// skipped when kd_gain is zero, all through the single 33x33 multiplier
// ready is high whenever the sequencer is idle
// a full output register stalls the program on its last step
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module wheel_speed_pid_controller_top
    import wspid_pkg::*;
#(
    parameter int COUNTER_BITS = WSPID_COUNTER_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    wspid_in_if.sink             i_in,
    wspid_out_if.source          o_out
);

    // configuration
    logic [15:0]        r_kp, r_ki, r_kd;
    logic signed [31:0] r_thr;
    logic [7:0]         r_lim;
    logic [31:0]        r_c2r, r_m2r;

    // captured word and state
    logic [COUNTER_BITS-1:0] r_count;
    logic [16:0]             r_mag;
    logic [1:0]              r_dir;
    logic                    r_turning;
    logic [31:0]             r_store;
    logic signed [31:0]      r_integ;
    logic signed [31:0]      r_prev;
    logic [23:0]             r_pwm;

    // datapath
    logic signed [65:0] r_prod;
    logic [30:0]        r_rps, r_sp, r_lin, r_ang;
    logic signed [31:0] r_err;
    logic signed [51:0] r_acc;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_pwm;
    logic [1:0]  r_out_dir;
    logic [30:0] r_out_rps, r_out_lin, r_out_ang;
    logic        r_out_turning;

    t_ctrl w_ctrl;
    logic  w_busy;
    logic  w_accept;
    logic  w_hold;

    logic [COUNTER_BITS-1:0] w_count_raw, w_count;
    logic signed [15:0]      w_sp, w_pp;
    logic                    w_sp_pos, w_sp_neg, w_pp_pos, w_pp_neg, w_turning;
    logic [16:0]             w_mag;
    logic [1:0]              w_dir;
    logic [32:0]             w_ssum;
    logic [31:0]             w_store_next;

    logic signed [32:0] w_a, w_b, w_derr;
    logic [30:0]        w_scaled;
    logic signed [31:0] w_err;
    logic signed [32:0] w_isum;
    logic signed [31:0] w_integ_next;
    logic signed [51:0] w_rnd;
    logic signed [43:0] w_sh;
    logic signed [31:0] w_pid;
    logic signed [33:0] w_psum;
    logic [23:0]        w_lim;
    logic [23:0]        n_pwm;

    wspid_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_hold    (w_hold),
        .i_kd_zero (r_kd == 16'd0),
        .o_ctrl    (w_ctrl),
        .o_busy    (w_busy)
    );

    assign i_in.ready = !w_busy;
    assign w_accept   = i_in.valid && !w_busy;
    assign w_hold     = r_out_valid && !o_out.ready;

    // input decode
    assign w_count_raw = COUNTER_BITS'(i_in.encoder_count);
    assign w_count     = (i_in.counting_down && (w_count_raw != '0)) ? ~w_count_raw
                                                                    : w_count_raw;
    assign w_sp        = i_in.wheel_setpoint;
    assign w_pp        = i_in.partner_setpoint;
    assign w_sp_neg    = w_sp[15];
    assign w_sp_pos    = !w_sp[15] && (w_sp != 16'sd0);
    assign w_pp_neg    = w_pp[15];
    assign w_pp_pos    = !w_pp[15] && (w_pp != 16'sd0);
    assign w_turning   = (w_sp_pos && w_pp_neg) || (w_sp_neg && w_pp_pos);
    assign w_mag       = w_sp_neg ? (17'd0 - {w_sp[15], w_sp}) : {1'b0, w_sp};
    assign w_dir       = w_sp_pos ? DIR_FWD : (w_sp_neg ? DIR_REV : DIR_STOP);
    assign w_ssum      = {1'b0, r_store} + 33'(w_count);
    assign w_store_next = !w_turning ? 32'd0 : (w_ssum[32] ? 32'hFFFF_FFFF : w_ssum[31:0]);

    // multiplier operands
    assign w_derr = {r_err[31], r_err} - {r_prev[31], r_prev};

    always_comb begin
        case (w_ctrl.uop.a_sel)
            A_COUNT: w_a = $signed(33'(r_count));
            A_MAG:   w_a = $signed({16'd0, r_mag});
            A_RPS:   w_a = $signed({2'd0, r_rps});
            A_STORE: w_a = $signed({1'b0, r_store});
            A_ERR:   w_a = {r_err[31], r_err};
            A_INTEG: w_a = {r_integ[31], r_integ};
            A_DERR:  w_a = w_derr;
            default: w_a = '0;
        endcase
    end

    always_comb begin
        case (w_ctrl.uop.b_sel)
            B_C2R:   w_b = $signed({1'b0, r_c2r});
            B_M2R:   w_b = $signed({1'b0, r_m2r});
            B_LIN:   w_b = $signed({1'b0, LIN_K});
            B_ANG:   w_b = $signed({1'b0, ANG_K});
            B_KP:    w_b = $signed({17'd0, r_kp});
            B_KI:    w_b = $signed({17'd0, r_ki});
            B_KD:    w_b = $signed({17'd0, r_kd});
            default: w_b = '0;
        endcase
    end

    // scaling, error, integral with separation
    assign w_scaled = wspid_scale(r_prod[63:0]);
    assign w_err    = $signed({1'b0, r_sp}) - $signed({1'b0, r_rps});
    assign w_isum   = {r_integ[31], r_integ} + {r_err[31], r_err};

    always_comb begin
        if (r_err >= r_thr) begin
            w_integ_next = 32'sd0;
        end else if (w_isum[32] != w_isum[31]) begin
            w_integ_next = w_isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_integ_next = w_isum[31:0];
        end
    end

    // pid rounding and pwm accumulator clamp
    assign w_rnd = r_acc + 52'sd128;
    assign w_sh  = w_rnd[51:8];
    assign w_lim = {r_lim, 16'd0};

    always_comb begin
        if ((w_sh[43:31] == '0) || (w_sh[43:31] == '1)) begin
            w_pid = w_sh[31:0];
        end else begin
            w_pid = w_sh[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    assign w_psum = $signed({10'd0, r_pwm}) + {{2{w_pid[31]}}, w_pid};

    always_comb begin
        if (w_psum >= $signed({10'd0, w_lim})) begin
            n_pwm = w_lim;
        end else if (w_psum[33]) begin
            n_pwm = 24'd0;
        end else begin
            n_pwm = w_psum[23:0];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= KP_RST;
            r_ki  <= KI_RST;
            r_kd  <= KD_RST;
            r_thr <= THR_RST;
            r_lim <= LIM_RST;
            r_c2r <= C2R_RST;
            r_m2r <= M2R_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:  r_kp  <= i_cfg_data[15:0];
                CFG_KI:  r_ki  <= i_cfg_data[15:0];
                CFG_KD:  r_kd  <= i_cfg_data[15:0];
                CFG_THR: r_thr <= i_cfg_data;
                CFG_LIM: r_lim <= i_cfg_data[7:0];
                CFG_C2R: r_c2r <= i_cfg_data;
                CFG_M2R: r_m2r <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= 32'd0;
            r_integ <= 32'sd0;
            r_prev  <= 32'sd0;
            r_pwm   <= 24'd0;
        end else begin
            if (w_accept) begin
                r_store <= w_store_next;
            end
            if (w_ctrl.adv && w_ctrl.uop.integ_ld) begin
                r_integ <= w_integ_next;
            end
            if (w_ctrl.adv && w_ctrl.uop.fin) begin
                r_prev <= r_err;
                r_pwm  <= n_pwm;
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_count   <= w_count;
            r_mag     <= w_mag;
            r_dir     <= w_dir;
            r_turning <= w_turning;
        end
        if (w_ctrl.active) begin
            r_prod <= w_a * w_b;
        end
        if (w_ctrl.adv) begin
            case (w_ctrl.uop.dst)
                DST_NONE: begin
                end
                DST_RPS: r_rps <= w_scaled;
                DST_SP:  r_sp  <= w_scaled;
                DST_LIN: r_lin <= w_scaled;
                DST_ANG: r_ang <= w_scaled;
                default: begin
                end
            endcase
            if (w_ctrl.uop.err_ld) begin
                r_err <= w_err;
            end
            case (w_ctrl.uop.acc_op)
                ACC_NONE: begin
                end
                ACC_LOAD: r_acc <= r_prod[51:0];
                ACC_ADD:  r_acc <= r_acc + r_prod[51:0];
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.adv && w_ctrl.uop.fin) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.adv && w_ctrl.uop.fin) begin
            r_out_pwm     <= n_pwm[23:16];
            r_out_dir     <= r_dir;
            r_out_rps     <= r_rps;
            r_out_lin     <= r_lin;
            r_out_ang     <= r_ang;
            r_out_turning <= r_turning;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pwm_duty     = r_out_pwm;
    assign o_out.motor_dir    = r_out_dir;
    assign o_out.wheel_rps    = r_out_rps;
    assign o_out.linear_speed = r_out_lin;
    assign o_out.turn_angle   = r_out_ang;
    assign o_out.turning      = r_out_turning;

endmodule

/* hw/rtl/wspid_seq.sv */
// ----------------------------------------------------------------------------
// wspid_seq
// step counter and microcode rom driving the shared multiply datapath
// ----------------------------------------------------------------------------
module wspid_seq
    import wspid_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_hold,
    input  logic  i_kd_zero,
    output t_ctrl o_ctrl,
    output logic  o_busy
);

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic            n_busy;
    logic [PC_W-1:0] n_pc;
    t_uop            w_uop;
    logic            w_adv;
    logic            w_jump;

    assign w_uop = ucode(r_pc);
    assign w_adv = r_busy && !(w_uop.fin && i_hold);

    always_comb begin
        case (w_uop.jmp)
            JMP_NEVER:   w_jump = 1'b0;
            JMP_KD_ZERO: w_jump = i_kd_zero;
            default:     w_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = ST_RPS_MUL;
        end else if (w_adv) begin
            if (w_uop.fin) begin
                n_busy = 1'b0;
            end else if (w_jump) begin
                n_pc = w_uop.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ST_RPS_MUL;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_ctrl.active = r_busy;
    assign o_ctrl.adv    = w_adv;
    assign o_ctrl.uop    = w_uop;
    assign o_busy        = r_busy;

endmodule

/* hw/rtl/wspid_checker.sv */
// ----------------------------------------------------------------------------
// wspid_checker
// port-level checks of the wheel speed pid controller, bound to the top level
// ----------------------------------------------------------------------------
`include "wheel_speed_pid_controller_top_defines.svh"

module wspid_checker
    import wspid_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_pwm_duty,
    input logic [1:0]  i_motor_dir,
    input logic [30:0] i_wheel_rps,
    input logic [30:0] i_turn_angle,
    input logic        i_turning
);

    // a stalled result word holds
    `WSPID_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pwm_duty) && $stable(i_wheel_rps) && $stable(i_turn_angle))

    // an accepted word keeps the sequencer busy
    `WSPID_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // no turn, no angle
    `WSPID_ASSERT_IMP(a_angle_idle, i_clk, i_rst_n, i_out_valid && !i_turning, i_turn_angle == 31'd0)

    // turning needs a nonzero setpoint
    `WSPID_ASSERT_IMP(a_turn_dir, i_clk, i_rst_n, i_out_valid && i_turning, (i_motor_dir == DIR_FWD) || (i_motor_dir == DIR_REV))

endmodule

bind wheel_speed_pid_controller_top wspid_checker u_wspid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_pwm_duty   (o_out.pwm_duty),
    .i_motor_dir  (o_out.motor_dir),
    .i_wheel_rps  (o_out.wheel_rps),
    .i_turn_angle (o_out.turn_angle),
    .i_turning    (o_out.turning)
);
